[sv/bce_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier curve evaluator package
// Word types, function and micro-op codes, fixed widths and the exact
// division tables used to step the binomial coefficient.
// ----------------------------------------------------------------------------
package bce_pkg;

  localparam int MAX_POINTS_DEF  = 16;
  localparam int COORD_WIDTH_DEF = 32;

  localparam int FIELD_W = 32;
  localparam int T_W     = 17;
  localparam int PNOW_W  = 5;
  localparam int W_W     = 20;
  localparam int MUL_A_W = 30;
  localparam int MUL_B_W = 33;
  localparam int MUL_P_W = 64;
  localparam int BX_W    = 36;
  localparam int DIV_DEPTH = 32;
  localparam int DIV_SH_W  = 3;

  localparam logic [T_W-1:0] ONE_Q16 = T_W'(65536);

  typedef enum logic [2:0] {
    FUNC_RESET  = 3'd0,
    FUNC_SET    = 3'd1,
    FUNC_ADD    = 3'd2,
    FUNC_REMOVE = 3'd3,
    FUNC_EVAL   = 3'd4
  } bce_func_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_UPOW,
    OP_PUPT,
    OP_BHI,
    OP_BLO,
    OP_WX,
    OP_WY,
    OP_TPOW,
    OP_BNUM,
    OP_BDIV
  } bce_op_e;

  typedef struct packed {
    logic [2:0]                func;
    logic [3:0]                point_index;
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
    logic [T_W-1:0]            param_t;
  } bce_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] curve_x;
    logic signed [FIELD_W-1:0] curve_y;
    logic                      status;
    logic [PNOW_W-1:0]         points_now;
  } bce_out_t;

  typedef struct packed {
    bce_op_e op;
    logic    start;
    logic    item;
    logic    finish;
  } bce_cmd_t;

  typedef logic [MUL_A_W-1:0]  div_inv_t [DIV_DEPTH];
  typedef logic [DIV_SH_W-1:0] div_sh_t  [DIV_DEPTH];

  // inverse of an odd value mod 2^MUL_A_W (Newton iteration)
  function automatic logic [MUL_A_W-1:0] odd_inverse(logic [MUL_A_W-1:0] d);
    logic [MUL_A_W-1:0] v;
    v = d;
    for (int j = 0; j < 5; j++) begin
      v = v * (MUL_A_W'(2) - d * v);
    end
    return v;
  endfunction

  function automatic div_inv_t div_inv_table();
    div_inv_t           tab;
    logic [MUL_A_W-1:0] d;
    for (int i = 0; i < DIV_DEPTH; i++) begin
      d = MUL_A_W'(i + 1);
      for (int s = 0; s < 6; s++) begin
        if (!d[0]) d = d >> 1;
      end
      tab[i] = odd_inverse(d);
    end
    return tab;
  endfunction

  function automatic div_sh_t div_sh_table();
    div_sh_t            tab;
    logic [MUL_A_W-1:0] d;
    logic [DIV_SH_W-1:0] n;
    for (int i = 0; i < DIV_DEPTH; i++) begin
      d = MUL_A_W'(i + 1);
      n = '0;
      for (int s = 0; s < 6; s++) begin
        if (!d[0]) begin
          d = d >> 1;
          n = n + DIV_SH_W'(1);
        end
      end
      tab[i] = n;
    end
    return tab;
  endfunction

  // divisor i+1: shift out the twos, then multiply by the odd inverse
  localparam div_inv_t DIV_INV   = div_inv_table();
  localparam div_sh_t  DIV_SHIFT = div_sh_table();

endpackage

[sv/bezier_curve_evaluator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier curve evaluator
// Keeps 2 to MAX_POINTS signed Q16.16 control points and evaluates the curve
// at an unsigned Q1.16 parameter with Bernstein weights.
// ----------------------------------------------------------------------------
// Every input word gives exactly one result word. Reset, set, add and remove
// words finish in the accept cycle and their result appears the next cycle.
// An evaluate word over P points (n = P-1) sends all its products through one
// shared 30x33 multiplier, each issued and then written back: n for the powers
// of (1-t) and up to eight per point.
// A result word held by the output stall holds off the next input word; the
// next word can be taken in the cycle the previous result is read.
// ----------------------------------------------------------------------------
module bezier_curve_evaluator import bce_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  bce_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output bce_out_t out_data_o
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  bce_cmd_t                  cmd;
  logic [CNT_W-1:0]          ptr, rev, total;
  logic [MUL_A_W-1:0]        mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  bce_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (in_data_i.func),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .total_i    (total),
    .cmd_o      (cmd),
    .ptr_o      (ptr),
    .rev_o      (rev)
  );

  bce_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .ptr_i     (ptr),
    .rev_i     (rev),
    .total_o   (total),
    .mul_a_o   (mul_a),
    .mul_b_o   (mul_b),
    .prod_i    (prod),
    .out_data_o(out_data_o)
  );

  bce_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

endmodule

[sv/bce_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned by signed multiply with a registered product.
// ----------------------------------------------------------------------------
module bce_mul import bce_pkg::*; (
  input  logic                      clk_i,
  input  logic [MUL_A_W-1:0]        a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0] p_o
);

  logic signed [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= $signed({1'b0, a_i}) * b_i;
  end

  assign p_o = p_q;

endmodule

[sv/bce_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier datapath
// Control point table, power and weight registers, accumulators and the
// result word register. Product write-back follows the op issued last cycle.
// ----------------------------------------------------------------------------
module bce_dp import bce_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int CNT_W = $clog2(MAX_POINTS + 1),
  localparam int IDX_W = $clog2(MAX_POINTS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bce_in_t                   in_data_i,
  input  bce_cmd_t                  cmd_i,
  input  logic [CNT_W-1:0]          ptr_i,
  input  logic [CNT_W-1:0]          rev_i,
  output logic [CNT_W-1:0]          total_o,
  output logic [MUL_A_W-1:0]        mul_a_o,
  output logic signed [MUL_B_W-1:0] mul_b_o,
  input  logic signed [MUL_P_W-1:0] prod_i,
  output bce_out_t                  out_data_o
);

  localparam int ACC_W = 36 + $clog2(MAX_POINTS);
  localparam int SUM_W = ((ACC_W > COORD_WIDTH) ? ACC_W : COORD_WIDTH) + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    (SUM_W'(1) <<< (COORD_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  logic [CNT_W-1:0]          total_q, total_d;
  logic [MAX_POINTS-1:0]     valid_q;
  bce_op_e                   op_q;
  logic signed [FIELD_W-1:0] ctrl_x_q [MAX_POINTS];
  logic signed [FIELD_W-1:0] ctrl_y_q [MAX_POINTS];
  logic [T_W-1:0]            upow_q [MAX_POINTS];
  logic [T_W-1:0]            t_q, u_q, r_q, tpow_q;
  logic [MUL_A_W-1:0]        binom_q;
  logic [2*T_W-2:0]          p1_q;
  logic [W_W-1:0]            wa_q, w_q;
  logic [BX_W-1:0]           bx_q, bsh;
  logic signed [ACC_W-1:0]   sx_q, sy_q;
  bce_out_t                  out_q;

  logic                      item_bad, wr_en, clr;
  logic [IDX_W-1:0]          wr_idx, rd_idx, rev_idx;
  logic signed [FIELD_W-1:0] cx_rd, cy_rd;
  logic [T_W-1:0]            t_clamp;
  logic signed [MUL_P_W-1:0] prod_rnd, prod_shr;
  logic [T_W-1:0]            pow_rnd;
  logic signed [SUM_W-1:0]   sx_ext, sy_ext, sat_x, sat_y;

  assign rd_idx  = ptr_i[IDX_W-1:0];
  assign rev_idx = rev_i[IDX_W-1:0];
  assign cx_rd   = valid_q[rd_idx] ? ctrl_x_q[rd_idx] : '0;
  assign cy_rd   = valid_q[rd_idx] ? ctrl_y_q[rd_idx] : '0;
  assign t_clamp = (in_data_i.param_t > ONE_Q16) ? ONE_Q16 : in_data_i.param_t;
  assign bsh     = bx_q >> DIV_SHIFT[5'(ptr_i)];

  assign prod_rnd = prod_i + MUL_P_W'(32768);
  assign prod_shr = prod_rnd >>> 16;
  assign pow_rnd  = prod_rnd[T_W+15:16];

  always_comb begin
    mul_a_o = '0;
    mul_b_o = '0;
    unique case (cmd_i.op)
      OP_UPOW: begin
        mul_a_o = MUL_A_W'(r_q);
        mul_b_o = MUL_B_W'(u_q);
      end
      OP_PUPT: begin
        mul_a_o = MUL_A_W'(upow_q[rev_idx]);
        mul_b_o = MUL_B_W'(tpow_q);
      end
      OP_BHI: begin
        mul_a_o = binom_q;
        mul_b_o = MUL_B_W'(p1_q[2*T_W-2:16]);
      end
      OP_BLO: begin
        mul_a_o = binom_q;
        mul_b_o = MUL_B_W'(p1_q[15:0]);
      end
      OP_WX: begin
        mul_a_o = MUL_A_W'(w_q);
        mul_b_o = MUL_B_W'(cx_rd);
      end
      OP_WY: begin
        mul_a_o = MUL_A_W'(w_q);
        mul_b_o = MUL_B_W'(cy_rd);
      end
      OP_TPOW: begin
        mul_a_o = MUL_A_W'(tpow_q);
        mul_b_o = MUL_B_W'(t_q);
      end
      OP_BNUM: begin
        mul_a_o = binom_q;
        mul_b_o = MUL_B_W'(rev_i);
      end
      OP_BDIV: begin
        mul_a_o = DIV_INV[5'(ptr_i)];
        mul_b_o = MUL_B_W'(bsh[MUL_A_W-1:0]);
      end
      default: ;
    endcase
  end

  // table item decode
  always_comb begin
    total_d  = total_q;
    item_bad = 1'b0;
    wr_en    = 1'b0;
    clr      = 1'b0;
    wr_idx   = '0;
    unique case (in_data_i.func)
      FUNC_RESET: begin
        total_d = CNT_W'(2);
        clr     = 1'b1;
      end
      FUNC_SET: begin
        wr_idx = IDX_W'(in_data_i.point_index);
        if (32'(in_data_i.point_index) < 32'(total_q)) wr_en = 1'b1;
        else item_bad = 1'b1;
      end
      FUNC_ADD: begin
        wr_idx = total_q[IDX_W-1:0];
        if (32'(total_q) < 32'(MAX_POINTS)) begin
          wr_en   = 1'b1;
          total_d = total_q + CNT_W'(1);
        end else begin
          item_bad = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (total_q > CNT_W'(2)) total_d = total_q - CNT_W'(1);
        else item_bad = 1'b1;
      end
      FUNC_EVAL: ;
      default: item_bad = 1'b1;
    endcase
    if (!cmd_i.item) begin
      wr_en = 1'b0;
      clr   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= CNT_W'(2);
      valid_q <= '0;
      op_q    <= OP_NONE;
    end else begin
      op_q <= cmd_i.op;
      if (cmd_i.item) total_q <= total_d;
      if (clr) valid_q <= '0;
      else if (wr_en) valid_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ctrl_x_q[wr_idx] <= in_data_i.point_x;
      ctrl_y_q[wr_idx] <= in_data_i.point_y;
    end
    if (cmd_i.start) begin
      t_q       <= t_clamp;
      u_q       <= ONE_Q16 - t_clamp;
      r_q       <= ONE_Q16;
      upow_q[0] <= ONE_Q16;
      tpow_q    <= ONE_Q16;
      binom_q   <= MUL_A_W'(1);
      sx_q      <= '0;
      sy_q      <= '0;
    end else begin
      unique case (op_q)
        OP_UPOW: begin
          r_q             <= pow_rnd;
          upow_q[rd_idx]  <= pow_rnd;
        end
        OP_PUPT: p1_q    <= prod_i[2*T_W-2:0];
        OP_BHI:  wa_q    <= prod_i[W_W-1:0];
        OP_BLO:  w_q     <= wa_q + prod_shr[W_W-1:0];
        OP_WX:   sx_q    <= sx_q + prod_shr[ACC_W-1:0];
        OP_WY:   sy_q    <= sy_q + prod_shr[ACC_W-1:0];
        OP_TPOW: tpow_q  <= pow_rnd;
        OP_BNUM: bx_q    <= prod_i[BX_W-1:0];
        OP_BDIV: binom_q <= prod_i[MUL_A_W-1:0];
        default: ;
      endcase
    end
  end

  assign sx_ext = SUM_W'(sx_q);
  assign sy_ext = SUM_W'(sy_q);
  assign sat_x  = (sx_ext > SAT_HI) ? SAT_HI : ((sx_ext < SAT_LO) ? SAT_LO : sx_ext);
  assign sat_y  = (sy_ext > SAT_HI) ? SAT_HI : ((sy_ext < SAT_LO) ? SAT_LO : sy_ext);

  always_ff @(posedge clk_i) begin
    if (cmd_i.item) begin
      out_q.curve_x    <= '0;
      out_q.curve_y    <= '0;
      out_q.status     <= item_bad;
      out_q.points_now <= PNOW_W'(total_d);
    end else if (cmd_i.finish) begin
      out_q.curve_x    <= sat_x[FIELD_W-1:0];
      out_q.curve_y    <= sat_y[FIELD_W-1:0];
      out_q.status     <= 1'b0;
      out_q.points_now <= PNOW_W'(total_q);
    end
  end

  assign total_o    = total_q;
  assign out_data_o = out_q;

endmodule

[sv/bce_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier controller
// Accepts words, sequences the evaluate micro-ops (issue, then write-back)
// and owns the output word valid.
// ----------------------------------------------------------------------------
module bce_ctrl import bce_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       func_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  logic [CNT_W-1:0] total_i,
  output bce_cmd_t         cmd_o,
  output logic [CNT_W-1:0] ptr_o,
  output logic [CNT_W-1:0] rev_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_UPOW, S_PUPT, S_BHI, S_BLO, S_WX, S_WY,
    S_TPOW, S_BNUM, S_BDIV, S_FIN
  } state_e;

  state_e           state_q;
  logic             gap_q;
  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] n_q, cnt_q;
  logic             slot_free, accept, is_eval;
  bce_op_e          step_op;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && slot_free);
  assign accept    = in_valid_i && !in_stall_o;
  assign is_eval   = (func_i == FUNC_EVAL);

  always_comb begin
    unique case (state_q)
      S_UPOW:  step_op = OP_UPOW;
      S_PUPT:  step_op = OP_PUPT;
      S_BHI:   step_op = OP_BHI;
      S_BLO:   step_op = OP_BLO;
      S_WX:    step_op = OP_WX;
      S_WY:    step_op = OP_WY;
      S_TPOW:  step_op = OP_TPOW;
      S_BNUM:  step_op = OP_BNUM;
      S_BDIV:  step_op = OP_BDIV;
      default: step_op = OP_NONE;
    endcase
  end

  assign cmd_o.op     = gap_q ? OP_NONE : step_op;
  assign cmd_o.start  = accept && is_eval;
  assign cmd_o.item   = accept && !is_eval;
  assign cmd_o.finish = (state_q == S_FIN) && slot_free;
  assign ptr_o        = cnt_q;
  assign rev_o        = n_q - cnt_q;
  assign out_valid_o  = out_valid_q;

  assign out_valid_d = (out_valid_q && out_stall_i) || (accept && !is_eval) ||
                       ((state_q == S_FIN) && slot_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gap_q       <= 1'b0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (accept && is_eval) begin
            n_q     <= total_i - CNT_W'(1);
            cnt_q   <= CNT_W'(1);
            gap_q   <= 1'b0;
            state_q <= S_UPOW;
          end
        end
        S_FIN: begin
          if (slot_free) state_q <= S_IDLE;
        end
        default: begin
          if (!gap_q) begin
            gap_q <= 1'b1;
          end else begin
            gap_q <= 1'b0;
            unique case (state_q)
              S_UPOW: begin
                if (cnt_q == n_q) begin
                  cnt_q   <= '0;
                  state_q <= S_PUPT;
                end else begin
                  cnt_q <= cnt_q + CNT_W'(1);
                end
              end
              S_PUPT: state_q <= S_BHI;
              S_BHI:  state_q <= S_BLO;
              S_BLO:  state_q <= S_WX;
              S_WX:   state_q <= S_WY;
              S_WY:   state_q <= (cnt_q == n_q) ? S_FIN : S_TPOW;
              S_TPOW: state_q <= S_BNUM;
              S_BNUM: state_q <= S_BDIV;
              S_BDIV: begin
                cnt_q   <= cnt_q + CNT_W'(1);
                state_q <= S_PUPT;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

endmodule

[tb/bezier_curve_evaluator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier curve evaluator testbench
// Drives table edits and curve evaluations with random handshake idling,
// predicts every result word from a fixed-point Bernstein model and compares.
// ----------------------------------------------------------------------------
module bezier_curve_evaluator_test;
  import bce_pkg::*;

  localparam int NPTS = 16;
  localparam longint CYCLE_LIMIT = 3000000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  bce_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  bce_out_t out_data_o;

  bezier_curve_evaluator dut (.*);

  always #10 clk_i = ~clk_i;

  // predictor state
  longint   pt_x [NPTS];
  longint   pt_y [NPTS];
  int       pt_count;
  bce_out_t curve_q [$];
  int       fails = 0;
  int       n_eval = 0, n_ign = 0, n_items = 0;
  bit       no_idle = 1'b0;
  bit       hold_rx = 1'b0;
  longint   cyc = 0;

  function automatic longint q16_mul(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic longint q16_pow(longint base, int k);
    longint r = 65536;
    for (int j = 0; j < k; j++) r = q16_mul(r, base);
    return r;
  endfunction

  function automatic longint q16_round(longint p);
    longint v = p + 32768;
    if (v >= 0) return v >>> 16;
    return -((-v + 65535) >>> 16);
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic bce_out_t predict_curve(bce_in_t w);
    bce_out_t r = '0;
    longint t, u, binom, wt, sx, sy;
    int n;
    case (w.func)
      FUNC_RESET: begin
        foreach (pt_x[i]) begin pt_x[i] = 0; pt_y[i] = 0; end
        pt_count = 2;
      end
      FUNC_SET:
        if (w.point_index < pt_count) begin
          pt_x[w.point_index] = w.point_x;
          pt_y[w.point_index] = w.point_y;
        end else r.status = 1'b1;
      FUNC_ADD:
        if (pt_count < NPTS) begin
          pt_x[pt_count] = w.point_x;
          pt_y[pt_count] = w.point_y;
          pt_count++;
        end else r.status = 1'b1;
      FUNC_REMOVE:
        if (pt_count > 2) pt_count--;
        else r.status = 1'b1;
      FUNC_EVAL: begin
        t = (w.param_t > 65536) ? 65536 : longint'(w.param_t);
        u = 65536 - t;
        n = pt_count - 1;
        binom = 1; sx = 0; sy = 0;
        for (int i = 0; i <= n; i++) begin
          wt = (binom * q16_pow(u, n - i) * q16_pow(t, i) + 32768) >>> 16;
          sx += q16_round(wt * pt_x[i]);
          sy += q16_round(wt * pt_y[i]);
          binom = binom * (n - i) / (i + 1);
        end
        r.curve_x = sat32(sx);
        r.curve_y = sat32(sy);
      end
      default: r.status = 1'b1;
    endcase
    r.points_now = pt_count[4:0];
    return r;
  endfunction

  // directed rows; fixed expectations only where obvious
  typedef struct {
    bce_in_t  word;
    bit       fixed;
    bce_out_t res;
  } row_t;
  row_t rows [$];

  function automatic bce_in_t mk(logic [2:0] f, logic [3:0] idx, int x, int y,
                                 logic [16:0] t);
    bce_in_t w;
    w.func = f; w.point_index = idx; w.point_x = x; w.point_y = y;
    w.param_t = t;
    return w;
  endfunction

  function automatic bce_out_t fx(logic s, logic [4:0] pn);
    bce_out_t r = '0;
    r.status = s; r.points_now = pn;
    return r;
  endfunction

  task automatic add_row(bce_in_t w, bit f = 0, bce_out_t r = '0);
    row_t e;
    e.word = w; e.fixed = f; e.res = r;
    rows = {rows, e};
  endtask

  task automatic send_word(bce_in_t w);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_items++;
    if (w.func == FUNC_EVAL) n_eval++;
  endtask

  task automatic push_expect(bce_in_t w);
    bce_out_t r = predict_curve(w);
    if (r.status) n_ign++;
    curve_q = {curve_q, r};
  endtask

  function automatic bce_in_t rand_word(bit edit_heavy);
    bce_in_t w;
    int k = $urandom_range(0, 99);
    w.point_index = $urandom_range(0, 15);
    w.point_x = $urandom;
    w.point_y = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      w.point_x = $signed(w.point_x) >>> $urandom_range(0, 31);
      w.point_y = $signed(w.point_y) >>> $urandom_range(0, 31);
    end
    w.param_t = ($urandom_range(0, 9) == 0) ? 17'($urandom) :
                17'($urandom_range(0, 65536));
    if (k < 2) w.func = FUNC_RESET;
    else if (k < 20) w.func = FUNC_SET;
    else if (k < (edit_heavy ? 50 : 36)) w.func = FUNC_ADD;
    else if (k < (edit_heavy ? 60 : 52)) w.func = FUNC_REMOVE;
    else if (k < 98) w.func = FUNC_EVAL;
    else w.func = 3'($urandom_range(5, 7));
    return w;
  endfunction

  // checker
  always @(posedge clk_i) begin
    bce_out_t exp_w;
    cyc <= cyc + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (curve_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %p", $time, out_data_o);
        fails++;
      end else begin
        exp_w = curve_q.pop_front();
        if (out_data_o.curve_x !== exp_w.curve_x) begin
          $display("%0t: curve_x expected %h actual %h", $time, exp_w.curve_x,
                   out_data_o.curve_x);
          fails++;
        end
        if (out_data_o.curve_y !== exp_w.curve_y) begin
          $display("%0t: curve_y expected %h actual %h", $time, exp_w.curve_y,
                   out_data_o.curve_y);
          fails++;
        end
        if (out_data_o.status !== exp_w.status) begin
          $display("%0t: status expected %b actual %b", $time, exp_w.status,
                   out_data_o.status);
          fails++;
        end
        if (out_data_o.points_now !== exp_w.points_now) begin
          $display("%0t: points_now expected %0d actual %0d", $time,
                   exp_w.points_now, out_data_o.points_now);
          fails++;
        end
      end
    end
  end

  // receiver stall
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_rx) begin
        out_stall_i <= 1'b1;
        n = 0;
        while (n < 400) begin @(posedge clk_i); n++; end
        hold_rx = 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (cyc >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    bce_in_t w;
    foreach (pt_x[i]) begin pt_x[i] = 0; pt_y[i] = 0; end
    pt_count = 2;

    add_row(mk(FUNC_EVAL, 0, 0, 0, 17'd32768), 1, fx(0, 2));
    add_row(mk(FUNC_REMOVE, 0, 0, 0, 0), 1, fx(1, 2));
    add_row(mk(FUNC_SET, 2, 5, 5, 0), 1, fx(1, 2));
    add_row(mk(FUNC_SET, 15, 5, 5, 0), 1, fx(1, 2));
    add_row(mk(3'd5, 0, 0, 0, 0), 1, fx(1, 2));
    add_row(mk(3'd7, 0, 0, 0, 0), 1, fx(1, 2));
    add_row(mk(FUNC_SET, 0, 32'h7fffffff, 32'h80000000, 0), 1, fx(0, 2));
    add_row(mk(FUNC_SET, 1, 32'h80000000, 32'h7fffffff, 0), 1, fx(0, 2));
    add_row(mk(FUNC_EVAL, 0, 0, 0, 17'd0));
    add_row(mk(FUNC_EVAL, 0, 0, 0, 17'd65536));
    add_row(mk(FUNC_EVAL, 0, 0, 0, 17'h1ffff));
    add_row(mk(FUNC_EVAL, 0, 0, 0, 17'd32768));
    for (int i = 0; i < 14; i++)
      add_row(mk(FUNC_ADD, 0, 32'h7fffffff, 32'h7fffffff, 0), 1, fx(0, 5'(i + 3)));
    add_row(mk(FUNC_ADD, 0, 1, 1, 0), 1, fx(1, 16));
    add_row(mk(FUNC_SET, 15, -65536, 65536, 0), 1, fx(0, 16));
    add_row(mk(FUNC_EVAL, 0, 0, 0, 17'd40000));
    add_row(mk(FUNC_EVAL, 0, 0, 0, 17'd1));
    add_row(mk(FUNC_RESET, 0, 0, 0, 0), 1, fx(0, 2));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      push_expect(rows[i].word);
      if (rows[i].fixed && rows[i].word.func != FUNC_EVAL &&
          curve_q[$] != rows[i].res) begin
        $display("%0t: table row %0d expected %p actual %p", $time, i,
                 rows[i].res, curve_q[$]);
        fails++;
      end
      if (rows[i].fixed && rows[i].word.func == FUNC_EVAL) curve_q[$] = rows[i].res;
      send_word(rows[i].word);
    end

    for (int i = 0; i < 1100; i++) begin
      if (i == 300) hold_rx = 1'b1;
      if (i == 950) no_idle = 1'b1;
      w = rand_word(i < 150 || (i > 500 && i < 650));
      push_expect(w);
      send_word(w);
    end
    in_valid_i <= 1'b0;

    while (curve_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("Ran %0d words: %0d curve evaluations, %0d rejected edits or codes.",
             n_items, n_eval, n_ign);
    if (fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
